// ===== rtl/sdr_pkg.sv =====
// ----------------------------------------------------------------------------
// sdr_pkg : shared types and constants for the signed divide/remainder unit
// Field widths, operation and status codes, and the per-item tag that rides
// along the divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sdr_pkg;

    // Fixed field widths at the ports
    localparam int FIELD_W      = 64;
    localparam int STATUS_W     = 2;
    localparam int DATA_WIDTH_D = 64;   // default operand width

    // Operation select
    typedef enum logic {
        CMD_QUO = 1'b0,
        CMD_REM = 1'b1
    } t_cmd;

    // Result status
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // Tag carried alongside the operands through every stage
    typedef struct packed {
        t_cmd    cmd;
        logic    neg_q;     // quotient must be negated
        logic    neg_r;     // remainder must be negated
        t_status status;
    } t_meta;

endpackage : sdr_pkg

`default_nettype wire

// ===== rtl/sdr_prep.sv =====
// ----------------------------------------------------------------------------
// sdr_prep : operand conditioning stage
// Trims operands to DATA_WIDTH bits, flags divide-by-zero and overflow,
// records result signs and hands unsigned magnitudes to the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

module sdr_prep #(
    parameter int DATA_WIDTH = sdr_pkg::DATA_WIDTH_D
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_ce,
    input  wire                          i_valid,
    input  wire sdr_pkg::t_cmd           i_cmd,
    input  wire [sdr_pkg::FIELD_W-1:0]   i_dividend,
    input  wire [sdr_pkg::FIELD_W-1:0]   i_divisor,
    output logic                         o_valid,
    output sdr_pkg::t_meta               o_meta,
    output logic [DATA_WIDTH-1:0]        o_rem,
    output logic [DATA_WIDTH-1:0]        o_dvd,
    output logic [DATA_WIDTH-1:0]        o_dsr
);
    import sdr_pkg::*;

    localparam logic [DATA_WIDTH-1:0] MOST_NEG  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] MINUS_ONE = {DATA_WIDTH{1'b1}};

    logic [DATA_WIDTH-1:0] a, b, ma, mb;
    logic                  neg_a, neg_b;
    t_meta                 n_meta;

    logic                  r_valid;
    t_meta                 r_meta;
    logic [DATA_WIDTH-1:0] r_dvd, r_dsr;

    always_comb begin
        a     = i_dividend[DATA_WIDTH-1:0];
        b     = i_divisor[DATA_WIDTH-1:0];
        neg_a = a[DATA_WIDTH-1];
        neg_b = b[DATA_WIDTH-1];
        ma    = neg_a ? (~a + 1'b1) : a;
        mb    = neg_b ? (~b + 1'b1) : b;
        n_meta.cmd   = i_cmd;
        n_meta.neg_q = neg_a ^ neg_b;
        n_meta.neg_r = neg_a;
        if (b == '0) begin
            n_meta.status = ST_DIV_ZERO;
        end else if (b == MINUS_ONE && a == MOST_NEG) begin
            n_meta.status = ST_OVERFLOW;
        end else begin
            n_meta.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_meta <= n_meta;
            r_dvd  <= ma;
            r_dsr  <= mb;
        end
    end

    assign o_valid = r_valid;
    assign o_meta  = r_meta;
    assign o_rem   = '0;
    assign o_dvd   = r_dvd;
    assign o_dsr   = r_dsr;

endmodule : sdr_prep

`default_nettype wire

// ===== rtl/sdr_cell.sv =====
// ----------------------------------------------------------------------------
// sdr_cell : one restoring-division step
// Shifts the next dividend bit into the partial remainder, trial-subtracts
// the divisor and shifts the quotient bit into the dividend register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdr_cell #(
    parameter int DATA_WIDTH = sdr_pkg::DATA_WIDTH_D
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_ce,
    input  wire                    i_valid,
    input  wire sdr_pkg::t_meta    i_meta,
    input  wire [DATA_WIDTH-1:0]   i_rem,
    input  wire [DATA_WIDTH-1:0]   i_dvd,
    input  wire [DATA_WIDTH-1:0]   i_dsr,
    output logic                   o_valid,
    output sdr_pkg::t_meta         o_meta,
    output logic [DATA_WIDTH-1:0]  o_rem,
    output logic [DATA_WIDTH-1:0]  o_dvd,
    output logic [DATA_WIDTH-1:0]  o_dsr
);
    import sdr_pkg::*;

    logic [DATA_WIDTH:0]   trial, diff;
    logic                  qbit;
    logic [DATA_WIDTH-1:0] n_rem, n_dvd;

    logic                  r_valid;
    t_meta                 r_meta;
    logic [DATA_WIDTH-1:0] r_rem, r_dvd, r_dsr;

    always_comb begin
        trial = {i_rem, i_dvd[DATA_WIDTH-1]};
        diff  = trial - {1'b0, i_dsr};
        qbit  = ~diff[DATA_WIDTH];               // no borrow: divisor fits
        n_rem = qbit ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
        n_dvd = {i_dvd[DATA_WIDTH-2:0], qbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_meta <= i_meta;
            r_rem  <= n_rem;
            r_dvd  <= n_dvd;
            r_dsr  <= i_dsr;
        end
    end

    assign o_valid = r_valid;
    assign o_meta  = r_meta;
    assign o_rem   = r_rem;
    assign o_dvd   = r_dvd;
    assign o_dsr   = r_dsr;

endmodule : sdr_cell

`default_nettype wire

// ===== rtl/sdr_post.sv =====
// ----------------------------------------------------------------------------
// sdr_post : sign fix-up and output register
// Picks quotient or remainder, restores the sign, forces zero on error
// status and holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sdr_post #(
    parameter int DATA_WIDTH = sdr_pkg::DATA_WIDTH_D
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_ce,
    input  wire                          i_valid,
    input  wire sdr_pkg::t_meta          i_meta,
    input  wire [DATA_WIDTH-1:0]         i_rem,
    input  wire [DATA_WIDTH-1:0]         i_quo,
    output logic                         o_valid,
    output sdr_pkg::t_status             o_status,
    output logic [sdr_pkg::FIELD_W-1:0]  o_value
);
    import sdr_pkg::*;

    logic [DATA_WIDTH-1:0] mag, sres;
    logic                  neg;
    logic [FIELD_W-1:0]    n_value;

    logic                  r_valid;
    t_status               r_status;
    logic [FIELD_W-1:0]    r_value;

    always_comb begin
        if (i_meta.cmd == CMD_REM) begin
            mag = i_rem;
            neg = i_meta.neg_r;
        end else begin
            mag = i_quo;
            neg = i_meta.neg_q;
        end
        sres    = neg ? (~mag + 1'b1) : mag;
        n_value = (i_meta.status == ST_OK) ? FIELD_W'($signed(sres)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_status <= i_meta.status;
            r_value  <= n_value;
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_value  = r_value;

endmodule : sdr_post

`default_nettype wire

// ===== rtl/signed_divide_remainder_64.sv =====
// ----------------------------------------------------------------------------
// signed_divide_remainder_64 : pipelined signed divide / remainder unit
// Truncating two's-complement division with divide-by-zero and overflow status,
// one transaction per clock through a chain of division cells when not stalled.
// ----------------------------------------------------------------------------
// Each transaction on s_axis selects quotient or remainder and carries a
// dividend and divisor; only their low DATA_WIDTH bits count, taken as
// signed. The quotient truncates toward zero and the remainder takes the
// sign of the dividend. A zero divisor returns status divide-by-zero, and
// the most negative dividend over -1 returns status overflow, for either
// operation; in both cases the value is zero. Results leave on m_axis in
// order, one per input transaction, the value sign-extended to 64 bits.
// Throughput is one transaction per clock while the output is not stalled.
// The pipeline is one conditioning stage, one division cell per quotient
// bit, and the output register. The whole pipeline moves as one while the
// output register is empty or being taken, so s_axis_tready follows
// m_axis_tready combinationally when the output is full.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_divide_remainder_64 #(
    parameter int DATA_WIDTH = sdr_pkg::DATA_WIDTH_D    // operand width, 8..64
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // input stream
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire [2*sdr_pkg::FIELD_W-1:0]     s_axis_tdata,   // [63:0] dividend, [127:64] divisor
    input  wire                              s_axis_tuser,   // [0] cmd
    // result stream
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [sdr_pkg::FIELD_W-1:0]      m_axis_tdata,   // [63:0] value
    output logic [sdr_pkg::STATUS_W-1:0]     m_axis_tuser    // [1:0] status
);
    import sdr_pkg::*;

    // Chain taps: index 0 is the conditioning stage, DATA_WIDTH the last cell
    logic                  c_valid [0:DATA_WIDTH];
    t_meta                 c_meta  [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] c_rem   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] c_dvd   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] c_dsr   [0:DATA_WIDTH];

    logic    ce;        // pipeline advance
    logic    out_valid;
    t_status out_status;

    // Advance whenever the output register is free or draining
    assign ce            = !out_valid || m_axis_tready;
    assign s_axis_tready = ce;

    sdr_prep #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ce       (ce),
        .i_valid    (s_axis_tvalid),
        .i_cmd      (t_cmd'(s_axis_tuser)),
        .i_dividend (s_axis_tdata[FIELD_W-1:0]),
        .i_divisor  (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
        .o_valid    (c_valid[0]),
        .o_meta     (c_meta[0]),
        .o_rem      (c_rem[0]),
        .o_dvd      (c_dvd[0]),
        .o_dsr      (c_dsr[0])
    );

    // One cell per quotient bit, MSB first
    for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_cell
        sdr_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (ce),
            .i_valid (c_valid[g]),
            .i_meta  (c_meta[g]),
            .i_rem   (c_rem[g]),
            .i_dvd   (c_dvd[g]),
            .i_dsr   (c_dsr[g]),
            .o_valid (c_valid[g+1]),
            .o_meta  (c_meta[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_dvd   (c_dvd[g+1]),
            .o_dsr   (c_dsr[g+1])
        );
    end

    // After the last cell the dividend register holds the quotient magnitude
    sdr_post #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ce     (ce),
        .i_valid  (c_valid[DATA_WIDTH]),
        .i_meta   (c_meta[DATA_WIDTH]),
        .i_rem    (c_rem[DATA_WIDTH]),
        .i_quo    (c_dvd[DATA_WIDTH]),
        .o_valid  (out_valid),
        .o_status (out_status),
        .o_value  (m_axis_tdata)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tuser  = out_status;

endmodule : signed_divide_remainder_64

`default_nettype wire
